/* src/pfts_pkg.sv */
// shared types, codes and constants of the ready-queue scheduler
`timescale 1ns / 1ps

package pfts_pkg;

    localparam int TASK_W        = 5;
    localparam int PRIO_W        = 3;
    localparam int REQ_W         = 2;
    localparam int DEF_NUM_TASKS = 16;
    localparam int DEF_NUM_PRIOS = 8;

    localparam logic [REQ_W-1:0] REQ_INSERT   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_YIELD    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SCHEDULE = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [TASK_W-1:0] task_id;
        logic [PRIO_W-1:0] priority_req;
    } req_t;

    typedef struct packed {
        logic [TASK_W-1:0] run_id;
        logic              switched;
        logic              status;
    } rsp_t;

    typedef enum logic [1:0] {
        CH_HOLD,
        CH_INSERT,
        CH_POP
    } chain_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } state_t;

endpackage

/* src/priority_fifo_task_scheduler_top.sv */
// top level of the fixed-priority fifo ready-queue scheduler
//
// requests enter on the s_ channel (s_valid, s_ready, s_data) and one result
// per request leaves on the m_ channel (m_valid, m_ready, m_data)
// insert makes a task ready at a level, yield dispatches the head of the
// highest non-empty level, schedule requeues the running task then dispatches
// ready tasks live in a chain of cells kept sorted by level, oldest first
// within a level; a dispatch shifts the whole chain one cell toward the head
// insert, yield and the unused code take a single pass in the chain, schedule
// takes an insert pass, then a shift pass; the result goes through the result
// buffer and then the output register to m_valid; one request is taken per
// cycle while m_ready stays high, but s_ready is low during the shift pass
// a result buffer sits ahead of the output register, so a request is taken
// while a finished result waits; when m_ready stays low both slots fill and
// s_ready drops until the receiver takes a transfer
// reset (aresetn low, synchronous) empties every level, clears all queued
// marks and sets the running task to idle
`timescale 1ns / 1ps

module priority_fifo_task_scheduler_top
    import pfts_pkg::*;
#(
    parameter int NUM_TASKS = DEF_NUM_TASKS,
    parameter int NUM_PRIOS = DEF_NUM_PRIOS
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_data
);

    localparam int IW = $clog2(NUM_TASKS + 1);
    localparam int XW = $clog2(NUM_TASKS);
    localparam int PW = $clog2(NUM_PRIOS);
    localparam logic [IW-1:0] IDLE_ID = IW'(NUM_TASKS);
    localparam logic [PW-1:0] LOW_PRIO = PW'(NUM_PRIOS - 1);

    state_t               state_reg, state_next;
    logic [IW-1:0]        running_reg, running_next;
    logic [PW-1:0]        run_prio_reg, run_prio_next;
    logic [NUM_TASKS-1:0] queued_reg, queued_next;
    logic                 status_reg, status_next;
    logic                 pend_valid_reg, pend_valid_next;
    rsp_t                 pend_reg, pend_next;
    logic                 m_valid_reg, m_valid_next;
    rsp_t                 m_data_reg, m_data_next;

    chain_op_t            ch_op;
    logic [IW-1:0]        ch_id;
    logic [PW-1:0]        ch_prio;
    logic                 head_valid;
    logic [IW-1:0]        head_id;
    logic [PW-1:0]        head_prio;
    logic [NUM_TASKS-1:0] cell_valid;

    logic                 s_fire, m_load, res_write, set_q, clr_q, status_cur;
    logic                 tid_ok, run_ok;
    logic [XW-1:0]        tid_idx, run_idx, set_idx, head_idx;
    logic [PW-1:0]        req_prio;

    assign s_fire   = s_valid && s_ready;
    assign m_load   = pend_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = (state_reg == ST_IDLE) && (!pend_valid_reg || m_load);

    assign tid_ok   = 32'(s_data.task_id) < NUM_TASKS;
    assign run_ok   = 32'(running_reg) < NUM_TASKS;
    assign tid_idx  = XW'(s_data.task_id);
    assign run_idx  = running_reg[XW-1:0];
    assign head_idx = head_id[XW-1:0];
    assign req_prio = (32'(s_data.priority_req) >= NUM_PRIOS) ? LOW_PRIO
                                                              : PW'(s_data.priority_req);

    pfts_chain #(
        .NUM_TASKS(NUM_TASKS),
        .IW       (IW),
        .PW       (PW)
    ) u_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op        (ch_op),
        .ins_id    (ch_id),
        .ins_prio  (ch_prio),
        .head_valid(head_valid),
        .head_id   (head_id),
        .head_prio (head_prio),
        .valid_vec (cell_valid)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && (s_data.req_type == REQ_SCHEDULE)) begin
                    state_next = ST_POP;
                end
            end
            ST_POP: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of each state
    always_comb begin
        ch_op         = CH_HOLD;
        ch_id         = IW'(s_data.task_id);
        ch_prio       = req_prio;
        set_q         = 1'b0;
        set_idx       = tid_idx;
        clr_q         = 1'b0;
        res_write     = 1'b0;
        status_cur    = 1'b0;
        status_next   = status_reg;
        running_next  = running_reg;
        run_prio_next = run_prio_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    unique case (s_data.req_type)
                        REQ_INSERT: begin
                            res_write = 1'b1;
                            if (tid_ok) begin
                                if (queued_reg[tid_idx]) begin
                                    status_cur = 1'b1;
                                end else begin
                                    ch_op = CH_INSERT;
                                    set_q = 1'b1;
                                end
                            end
                        end
                        REQ_YIELD: begin
                            res_write     = 1'b1;
                            ch_op         = CH_POP;
                            clr_q         = head_valid;
                            running_next  = head_valid ? head_id : IDLE_ID;
                            run_prio_next = head_prio;
                        end
                        REQ_SCHEDULE: begin
                            status_next = 1'b0;
                            if (run_ok) begin
                                if (queued_reg[run_idx]) begin
                                    status_next = 1'b1;
                                end else begin
                                    ch_op   = CH_INSERT;
                                    ch_id   = running_reg;
                                    ch_prio = run_prio_reg;
                                    set_q   = 1'b1;
                                    set_idx = run_idx;
                                end
                            end
                        end
                        default: begin
                            res_write = 1'b1;
                        end
                    endcase
                end
            end
            ST_POP: begin
                res_write     = 1'b1;
                status_cur    = status_reg;
                ch_op         = CH_POP;
                clr_q         = head_valid;
                running_next  = head_valid ? head_id : IDLE_ID;
                run_prio_next = head_prio;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        queued_next = queued_reg;
        if (set_q) begin
            queued_next[set_idx] = 1'b1;
        end
        if (clr_q) begin
            queued_next[head_idx] = 1'b0;
        end
    end

    // result buffer and output register
    always_comb begin
        pend_valid_next = pend_valid_reg && !m_load;
        pend_next       = pend_reg;
        if (res_write) begin
            pend_valid_next    = 1'b1;
            pend_next.run_id   = TASK_W'(running_next);
            pend_next.switched = running_next != running_reg;
            pend_next.status   = status_cur;
        end
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (m_load) begin
            m_valid_next = 1'b1;
            m_data_next  = pend_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            running_reg    <= IDLE_ID;
            queued_reg     <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            running_reg    <= running_next;
            queued_reg     <= queued_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        run_prio_reg <= run_prio_next;
        status_reg   <= status_next;
        pend_reg     <= pend_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // queued marks track the chain occupancy
    assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(queued_reg) == $countones(cell_valid))
        else $error("queued marks disagree with chain occupancy");

    // a waiting result in the buffer holds until it moves to the output
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_valid_reg && !m_load) |=> (pend_valid_reg && $stable(pend_reg)))
        else $error("buffered result lost or changed");

    // schedule always takes its second pass
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (s_data.req_type == REQ_SCHEDULE)) |=> (state_reg == ST_POP))
        else $error("schedule did not enter dispatch pass");

    // chain head is never a task marked as not queued
    assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid |-> queued_reg[head_idx])
        else $error("chain head not marked queued");

endmodule

/* src/pfts_cell.sv */
// one slot of the sorted ready chain: holds a task id and its priority
`timescale 1ns / 1ps

module pfts_cell
    import pfts_pkg::*;
#(
    parameter int IW = 5,
    parameter int PW = 3
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  chain_op_t     op,
    input  logic [IW-1:0] ins_id,
    input  logic [PW-1:0] ins_prio,
    input  logic          left_open,
    input  logic          left_valid,
    input  logic [IW-1:0] left_id,
    input  logic [PW-1:0] left_prio,
    input  logic          right_valid,
    input  logic [IW-1:0] right_id,
    input  logic [PW-1:0] right_prio,
    output logic          open_o,
    output logic          valid_o,
    output logic [IW-1:0] id_o,
    output logic [PW-1:0] prio_o
);

    logic          valid_reg, valid_next;
    logic [IW-1:0] id_reg, id_next;
    logic [PW-1:0] prio_reg, prio_next;

    // new entry goes ahead of this cell: empty or strictly lower level
    assign open_o = !valid_reg || (prio_reg > ins_prio);

    always_comb begin
        valid_next = valid_reg;
        id_next    = id_reg;
        prio_next  = prio_reg;
        unique case (op)
            CH_INSERT: begin
                if (open_o) begin
                    if (left_open) begin
                        valid_next = left_valid;
                        id_next    = left_id;
                        prio_next  = left_prio;
                    end else begin
                        valid_next = 1'b1;
                        id_next    = ins_id;
                        prio_next  = ins_prio;
                    end
                end
            end
            CH_POP: begin
                valid_next = right_valid;
                id_next    = right_id;
                prio_next  = right_prio;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        id_reg   <= id_next;
        prio_reg <= prio_next;
    end

    assign valid_o = valid_reg;
    assign id_o    = id_reg;
    assign prio_o  = prio_reg;

endmodule

/* src/pfts_chain.sv */
// row of cells kept sorted by priority, fifo order within a level
`timescale 1ns / 1ps

module pfts_chain
    import pfts_pkg::*;
#(
    parameter int NUM_TASKS = DEF_NUM_TASKS,
    parameter int IW        = 5,
    parameter int PW        = 3
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  chain_op_t            op,
    input  logic [IW-1:0]        ins_id,
    input  logic [PW-1:0]        ins_prio,
    output logic                 head_valid,
    output logic [IW-1:0]        head_id,
    output logic [PW-1:0]        head_prio,
    output logic [NUM_TASKS-1:0] valid_vec
);

    logic [NUM_TASKS-1:0] open_vec;
    logic [IW-1:0]        id_arr   [NUM_TASKS];
    logic [PW-1:0]        prio_arr [NUM_TASKS];

    for (genvar i = 0; i < NUM_TASKS; i++) begin : g_cell
        logic          l_open, l_valid, r_valid;
        logic [IW-1:0] l_id, r_id;
        logic [PW-1:0] l_prio, r_prio;

        if (i == 0) begin : g_first
            assign l_open  = 1'b0;
            assign l_valid = 1'b0;
            assign l_id    = ins_id;
            assign l_prio  = ins_prio;
        end else begin : g_mid
            assign l_open  = open_vec[i-1];
            assign l_valid = valid_vec[i-1];
            assign l_id    = id_arr[i-1];
            assign l_prio  = prio_arr[i-1];
        end

        if (i == NUM_TASKS - 1) begin : g_last
            assign r_valid = 1'b0;
            assign r_id    = '0;
            assign r_prio  = '0;
        end else begin : g_inner
            assign r_valid = valid_vec[i+1];
            assign r_id    = id_arr[i+1];
            assign r_prio  = prio_arr[i+1];
        end

        pfts_cell #(
            .IW(IW),
            .PW(PW)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .op         (op),
            .ins_id     (ins_id),
            .ins_prio   (ins_prio),
            .left_open  (l_open),
            .left_valid (l_valid),
            .left_id    (l_id),
            .left_prio  (l_prio),
            .right_valid(r_valid),
            .right_id   (r_id),
            .right_prio (r_prio),
            .open_o     (open_vec[i]),
            .valid_o    (valid_vec[i]),
            .id_o       (id_arr[i]),
            .prio_o     (prio_arr[i])
        );
    end

    assign head_valid = valid_vec[0];
    assign head_id    = id_arr[0];
    assign head_prio  = prio_arr[0];

endmodule
